@@ design/scfa_pkg.sv @@
// Shared types and codes for the second-chance frame allocator.
package scfa_pkg;

    typedef enum logic [1:0] {
        KIND_ALLOC   = 2'd0,
        KIND_REF     = 2'd1,
        KIND_RELEASE = 2'd2,
        KIND_DIRTY   = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        ST_FREE    = 3'd0,
        ST_REPLACE = 3'd1,
        ST_NONE    = 3'd2,
        ST_DONE    = 3'd3,
        ST_IGNORED = 3'd4
    } status_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_CHK,
        S_AF_LINK,
        S_AF_HAND,
        S_SW_REF,
        S_SW_EVAL,
        S_RM_WALK,
        S_RM_LINK,
        S_OUT
    } ctrl_state_t;

    typedef enum logic [3:0] {
        OP_IDLE,
        OP_CLEAR,
        OP_DECODE,
        OP_CHK,
        OP_AF_LINK,
        OP_AF_HAND,
        OP_SW_REF,
        OP_SW_EVAL,
        OP_RM_WALK,
        OP_RM_LINK,
        OP_PUSH
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
        logic   accept;
    } dp_cmd_t;

    typedef struct packed {
        kind_t kind;
        logic  in_range;
        logic  free_nz;
        logic  used_nz;
        logic  used_le1;
        logic  inr_rd;
        logic  ref_rd;
        logic  walk_hit;
        logic  clr_last;
        logic  out_busy;
    } dp_stat_t;

endpackage

@@ design/scfa_ctrl.sv @@
// Sequencer for the frame allocator: steps one request through the datapath.
module scfa_ctrl
    import scfa_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_tvalid,
    output logic     s_tready,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    ctrl_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd.op     = OP_IDLE;
        cmd.accept = 1'b0;
        s_tready   = 1'b0;
        unique case (state_reg)
            S_CLEAR: begin
                cmd.op = OP_CLEAR;
                if (stat.clr_last) state_next = S_IDLE;
            end
            S_IDLE: begin
                s_tready   = 1'b1;
                cmd.accept = s_tvalid;
                if (s_tvalid) state_next = S_DECODE;
            end
            S_DECODE: begin
                cmd.op = OP_DECODE;
                unique case (stat.kind)
                    KIND_ALLOC: begin
                        if (stat.free_nz)      state_next = S_AF_LINK;
                        else if (stat.used_nz) state_next = S_SW_REF;
                        else                   state_next = S_OUT;
                    end
                    KIND_REF, KIND_RELEASE: begin
                        state_next = stat.in_range ? S_CHK : S_OUT;
                    end
                    default: state_next = S_OUT;
                endcase
            end
            S_CHK: begin
                cmd.op = OP_CHK;
                if (stat.inr_rd && stat.kind == KIND_RELEASE && !stat.used_le1)
                    state_next = S_RM_WALK;
                else
                    state_next = S_OUT;
            end
            S_RM_WALK: begin
                cmd.op = OP_RM_WALK;
                if (stat.walk_hit) state_next = S_RM_LINK;
            end
            S_RM_LINK: begin
                cmd.op     = OP_RM_LINK;
                state_next = S_OUT;
            end
            S_AF_LINK: begin
                cmd.op     = OP_AF_LINK;
                state_next = stat.used_nz ? S_AF_HAND : S_OUT;
            end
            S_AF_HAND: begin
                cmd.op     = OP_AF_HAND;
                state_next = S_OUT;
            end
            S_SW_REF: begin
                cmd.op     = OP_SW_REF;
                state_next = S_SW_EVAL;
            end
            S_SW_EVAL: begin
                cmd.op     = OP_SW_EVAL;
                state_next = stat.ref_rd ? S_SW_REF : S_OUT;
            end
            S_OUT: begin
                if (!stat.out_busy) begin
                    cmd.op     = OP_PUSH;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_CLEAR;
        endcase
    end

endmodule

@@ design/scfa_dp.sv @@
// Datapath: free queue, ring links, per-frame bits, pointers and result beat.
module scfa_dp
    import scfa_pkg::*;
#(
    parameter int NUM_FRAMES = 1024
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  dp_cmd_t     cmd,
    output dp_stat_t    stat,
    input  logic [15:0] s_tdata,
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,
    output logic [3:0]  m_tuser
);

    localparam int FW = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
    localparam int CW = $clog2(NUM_FRAMES + 1);
    localparam logic [FW-1:0] LAST_IDX = FW'(NUM_FRAMES - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(NUM_FRAMES);

    // storage
    logic [FW-1:0] fq_mem   [NUM_FRAMES];
    logic [FW-1:0] next_mem [NUM_FRAMES];
    logic          ref_mem  [NUM_FRAMES];
    logic          inr_mem  [NUM_FRAMES];
    logic          dirty_mem[NUM_FRAMES];

    logic [FW-1:0] fq_rd_reg, next_rd_reg;
    logic          ref_rd_reg, inr_rd_reg, dirty_rd_reg;

    logic [FW-1:0] clr_reg, clr_next;
    logic [FW-1:0] head_reg, head_next, tail_reg, tail_next;
    logic [CW-1:0] free_reg, free_next, used_reg, used_next;
    logic [FW-1:0] hand_reg, hand_next, ptr_reg, ptr_next;
    kind_t         kind_reg, kind_next;
    logic [9:0]    frame_reg, frame_next;
    logic [FW-1:0] res_gr_reg, res_gr_next;
    status_t       res_st_reg, res_st_next;
    logic          res_wb_reg, res_wb_next;
    logic          out_valid_reg, out_valid_next;
    logic [FW-1:0] out_gr_reg, out_gr_next;
    status_t       out_st_reg, out_st_next;
    logic          out_wb_reg, out_wb_next;

    logic [FW-1:0] fidx, next_raddr, bits_raddr;
    logic          in_range;

    logic          fq_we, next_we, ref_we, inr_we, dirty_we;
    logic [FW-1:0] fq_wa, fq_wd, next_wa, next_wd, ref_wa, inr_wa, dirty_wa;
    logic          ref_wd, inr_wd, dirty_wd;

    assign fidx     = FW'(frame_reg);
    assign in_range = 32'(frame_reg) < NUM_FRAMES;

    always_comb begin
        next_raddr = hand_reg;
        bits_raddr = fidx;
        unique case (cmd.op)
            OP_RM_WALK: next_raddr = (next_rd_reg == fidx) ? fidx : next_rd_reg;
            OP_SW_EVAL: next_raddr = ptr_reg;
            OP_SW_REF:  bits_raddr = next_rd_reg;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        fq_rd_reg    <= fq_mem[head_reg];
        next_rd_reg  <= next_mem[next_raddr];
        ref_rd_reg   <= ref_mem[bits_raddr];
        inr_rd_reg   <= inr_mem[bits_raddr];
        dirty_rd_reg <= dirty_mem[bits_raddr];
        if (fq_we)    fq_mem[fq_wa]       <= fq_wd;
        if (next_we)  next_mem[next_wa]   <= next_wd;
        if (ref_we)   ref_mem[ref_wa]     <= ref_wd;
        if (inr_we)   inr_mem[inr_wa]     <= inr_wd;
        if (dirty_we) dirty_mem[dirty_wa] <= dirty_wd;
    end

    always_comb begin
        clr_next       = clr_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        free_next      = free_reg;
        used_next      = used_reg;
        hand_next      = hand_reg;
        ptr_next       = ptr_reg;
        kind_next      = kind_reg;
        frame_next     = frame_reg;
        res_gr_next    = res_gr_reg;
        res_st_next    = res_st_reg;
        res_wb_next    = res_wb_reg;
        out_gr_next    = out_gr_reg;
        out_st_next    = out_st_reg;
        out_wb_next    = out_wb_reg;
        out_valid_next = out_valid_reg && !m_tready;
        fq_we = 1'b0;   fq_wa = tail_reg;  fq_wd = fidx;
        next_we = 1'b0; next_wa = ptr_reg; next_wd = next_rd_reg;
        ref_we = 1'b0;  ref_wa = fidx;     ref_wd = 1'b0;
        inr_we = 1'b0;  inr_wa = fidx;     inr_wd = 1'b0;
        dirty_we = 1'b0; dirty_wa = fidx;  dirty_wd = 1'b0;

        unique case (cmd.op)
            OP_CLEAR: begin
                fq_we = 1'b1; fq_wa = clr_reg; fq_wd = clr_reg;
                ref_we = 1'b1; ref_wa = clr_reg;
                inr_we = 1'b1; inr_wa = clr_reg;
                dirty_we = 1'b1; dirty_wa = clr_reg;
                clr_next = clr_reg + 1'b1;
            end
            OP_IDLE: begin
                if (cmd.accept) begin
                    kind_next  = kind_t'(s_tuser);
                    frame_next = s_tdata[9:0];
                end
            end
            OP_DECODE: begin
                res_gr_next = '0;
                res_wb_next = 1'b0;
                res_st_next = ST_IGNORED;
                if (kind_reg == KIND_ALLOC && free_reg == '0 && used_reg == '0)
                    res_st_next = ST_NONE;
                if (kind_reg == KIND_DIRTY && in_range) begin
                    dirty_we    = 1'b1;
                    dirty_wd    = 1'b1;
                    res_st_next = ST_DONE;
                end
            end
            OP_CHK: begin
                ptr_next = hand_reg;
                if (inr_rd_reg) begin
                    res_st_next = ST_DONE;
                    if (kind_reg == KIND_REF) begin
                        ref_we = 1'b1;
                        ref_wd = 1'b1;
                    end else if (used_reg <= CW'(1)) begin
                        // last frame leaves the ring, hand keeps its value
                        used_next = '0;
                        ref_we    = 1'b1;
                        inr_we    = 1'b1;
                        if (free_reg < FULL_CNT) begin
                            fq_we     = 1'b1;
                            tail_next = (tail_reg == LAST_IDX) ? '0 : tail_reg + 1'b1;
                            free_next = free_reg + 1'b1;
                        end
                    end
                end
            end
            OP_RM_WALK: begin
                if (next_rd_reg != fidx) ptr_next = next_rd_reg;
            end
            OP_RM_LINK: begin
                // ptr is the predecessor, next_rd holds the successor
                next_we   = 1'b1;
                if (hand_reg == fidx) hand_next = ptr_reg;
                used_next = used_reg - 1'b1;
                ref_we    = 1'b1;
                inr_we    = 1'b1;
                if (free_reg < FULL_CNT) begin
                    fq_we     = 1'b1;
                    tail_next = (tail_reg == LAST_IDX) ? '0 : tail_reg + 1'b1;
                    free_next = free_reg + 1'b1;
                end
            end
            OP_AF_LINK: begin
                next_we     = 1'b1;
                next_wa     = fq_rd_reg;
                next_wd     = (used_reg == '0) ? fq_rd_reg : next_rd_reg;
                ref_we      = 1'b1; ref_wa = fq_rd_reg;
                inr_we      = 1'b1; inr_wa = fq_rd_reg; inr_wd = 1'b1;
                head_next   = (head_reg == LAST_IDX) ? '0 : head_reg + 1'b1;
                free_next   = free_reg - 1'b1;
                ptr_next    = fq_rd_reg;
                res_gr_next = fq_rd_reg;
                res_st_next = ST_FREE;
                if (used_reg == '0) begin
                    hand_next = fq_rd_reg;
                    used_next = used_reg + 1'b1;
                end
            end
            OP_AF_HAND: begin
                next_we   = 1'b1;
                next_wa   = hand_reg;
                next_wd   = ptr_reg;
                hand_next = ptr_reg;
                used_next = used_reg + 1'b1;
            end
            OP_SW_REF: begin
                ptr_next = next_rd_reg;
            end
            OP_SW_EVAL: begin
                if (ref_rd_reg) begin
                    ref_we = 1'b1;
                    ref_wa = ptr_reg;
                end else begin
                    dirty_we    = 1'b1;
                    dirty_wa    = ptr_reg;
                    hand_next   = ptr_reg;
                    res_gr_next = ptr_reg;
                    res_st_next = ST_REPLACE;
                    res_wb_next = dirty_rd_reg;
                end
            end
            OP_PUSH: begin
                out_valid_next = 1'b1;
                out_gr_next    = res_gr_reg;
                out_st_next    = res_st_reg;
                out_wb_next    = res_wb_reg;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_reg       <= '0;
            head_reg      <= '0;
            tail_reg      <= '0;
            free_reg      <= FULL_CNT;
            used_reg      <= '0;
            hand_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            clr_reg       <= clr_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            free_reg      <= free_next;
            used_reg      <= used_next;
            hand_reg      <= hand_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        ptr_reg    <= ptr_next;
        kind_reg   <= kind_next;
        frame_reg  <= frame_next;
        res_gr_reg <= res_gr_next;
        res_st_reg <= res_st_next;
        res_wb_reg <= res_wb_next;
        out_gr_reg <= out_gr_next;
        out_st_reg <= out_st_next;
        out_wb_reg <= out_wb_next;
    end

    assign stat.kind     = kind_reg;
    assign stat.in_range = in_range;
    assign stat.free_nz  = free_reg != '0;
    assign stat.used_nz  = used_reg != '0;
    assign stat.used_le1 = used_reg <= CW'(1);
    assign stat.inr_rd   = inr_rd_reg;
    assign stat.ref_rd   = ref_rd_reg;
    assign stat.walk_hit = next_rd_reg == fidx;
    assign stat.clr_last = clr_reg == LAST_IDX;
    assign stat.out_busy = out_valid_reg && !m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'b0, 10'(out_gr_reg)};
    assign m_tuser  = {out_wb_reg, out_st_reg};

    // every frame is either queued as free or linked in the ring;
    // the hand write cycle still owes the used count its increment
    a_conserve: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.op != OP_AF_HAND |->
        ((CW+1)'(free_reg) + (CW+1)'(used_reg)) == (CW+1)'(NUM_FRAMES))
        else $error("free and used counts do not add up");

    a_push_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.op == OP_PUSH |-> !(out_valid_reg && !m_tready))
        else $error("result pushed over a waiting beat");

    a_victim_ring: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.op == OP_SW_EVAL && !ref_rd_reg) |=> res_st_reg == ST_REPLACE && used_reg != '0)
        else $error("replacement grant with an empty ring");

endmodule

@@ design/second_chance_frame_allocator.sv @@
// Top level of the second-chance frame allocator: sequencer plus datapath.
//
//  channel  dir  ports                      payload
//  s_       in   tvalid tready tdata tuser  tdata[9:0] frame, tuser[1:0] kind
//  m_       out  tvalid tready tdata tuser  tdata[9:0] granted_frame,
//                                           tuser[2:0] status, tuser[3] writeback
//
//  One request at a time: each is accepted, decoded and its result pushed;
//  reference and release add a check step; allocate from the free queue adds
//  a link write, then a hand write on the single ring port if the ring was
//  not empty. Replacement adds a reference read and an evaluate step per
//  reference bit cleared by the sweep; release walks the ring one link a cycle
//  from the hand to find the predecessor. After reset a pass over every frame
//  loads the free queue and clears the frame bits; tready stays low meanwhile.
//  A waiting result beat does not stop the next request being accepted and worked.
module second_chance_frame_allocator
    import scfa_pkg::*;
#(
    parameter int NUM_FRAMES = 1024
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [9:0] frame
    input  logic [1:0]  s_tuser,   // [1:0] kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [9:0] granted_frame
    output logic [3:0]  m_tuser    // [2:0] status, [3] writeback
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    scfa_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    scfa_dp #(
        .NUM_FRAMES (NUM_FRAMES)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .stat     (stat),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

@@ test/second_chance_frame_allocator_tb.sv @@
// Self-checking testbench for the second-chance frame allocator.
`timescale 1ns / 1ps

module second_chance_frame_allocator_tb
    import scfa_pkg::*;
();

    localparam int FRAMES = 1024;
    // No beat may take longer than this, counting the reset clearing pass,
    // a full sweep of every reference bit and a full release walk.
    localparam int STALL_LIMIT = 20000;

    typedef struct packed {
        kind_t      kind;
        logic [9:0] frame;
    } request_t;

    typedef struct packed {
        logic [9:0] granted;
        status_t    status;
        logic       writeback;
    } grant_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic [3:0]  m_tuser;

    second_chance_frame_allocator dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),  // [9:0] frame
        .s_tuser  (s_tuser),  // [1:0] kind
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),  // [9:0] granted_frame
        .m_tuser  (m_tuser)   // [2:0] status, [3] writeback
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // ---- allocator shadow state ----
    logic [9:0] fq_slot [FRAMES];
    int         fq_head, fq_tail, fq_count;
    logic [9:0] succ [FRAMES];
    bit         refd [FRAMES];
    bit         linked [FRAMES];
    bit         dirty [FRAMES];
    logic [9:0] clock_hand;
    int         ring_size;

    request_t pending_reqs[$];
    grant_t   expected_grants[$];
    int       errors = 0;
    int       beats_in = 0;
    int       idle_cycles = 0;
    bit       quiet = 0;       // no idling in the final stretch
    bit       in_done = 0;     // input beat taken at the last rising edge

    task automatic shadow_reset();
        for (int i = 0; i < FRAMES; i++) begin
            fq_slot[i] = i[9:0];
            succ[i]    = '0;
            refd[i]    = 0;
            linked[i]  = 0;
            dirty[i]   = 0;
        end
        fq_head = 0; fq_tail = 0; fq_count = FRAMES;
        clock_hand = '0; ring_size = 0;
    endtask

    // Work out the grant one request produces, updating the shadow state.
    function automatic grant_t serve_request(request_t rq);
        grant_t     g;
        logic [9:0] f, p, q;
        int         guard;
        g = '{granted: '0, status: ST_IGNORED, writeback: 1'b0};
        if (rq.kind == KIND_ALLOC) begin
            if (fq_count > 0) begin
                f = fq_slot[fq_head];
                fq_head = (fq_head + 1) % FRAMES;
                fq_count--;
                // link just after the hand, becomes the new hand
                refd[f] = 0;
                linked[f] = 1;
                if (ring_size == 0) begin
                    succ[f] = f;
                end else begin
                    succ[f] = succ[clock_hand];
                    succ[clock_hand] = f;
                end
                clock_hand = f;
                ring_size++;
                g.granted = f;
                g.status = ST_FREE;
            end else if (ring_size > 0) begin
                // second chance sweep from the entry after the hand
                p = clock_hand;
                guard = 0;
                while (refd[succ[p]] && guard <= FRAMES) begin
                    refd[succ[p]] = 0;
                    p = succ[p];
                    guard++;
                end
                f = succ[p];
                g.writeback = dirty[f];
                dirty[f] = 0;
                refd[f] = 0;
                clock_hand = f;
                g.granted = f;
                g.status = ST_REPLACE;
            end else begin
                g.status = ST_NONE;
            end
        end else if (rq.kind == KIND_DIRTY) begin
            dirty[rq.frame] = 1;
            g.status = ST_DONE;
        end else if (linked[rq.frame]) begin
            f = rq.frame;
            if (rq.kind == KIND_REF) begin
                refd[f] = 1;
            end else begin
                if (ring_size <= 1) begin
                    ring_size = 0;
                end else begin
                    // find the predecessor, starting at the hand
                    q = clock_hand;
                    guard = 0;
                    while (succ[q] != f && guard <= FRAMES) begin
                        q = succ[q];
                        guard++;
                    end
                    succ[q] = succ[f];
                    if (clock_hand == f) clock_hand = q;
                    ring_size--;
                end
                linked[f] = 0;
                refd[f] = 0;
                if (fq_count < FRAMES) begin
                    fq_slot[fq_tail] = f;
                    fq_tail = (fq_tail + 1) % FRAMES;
                    fq_count++;
                end
            end
            g.status = ST_DONE;
        end
        return g;
    endfunction

    // ---- input driver: changes at the falling edge ----
    int gap_left = 0;
    always @(negedge aclk) begin
        request_t rq;
        if (aresetn && (!s_tvalid || in_done)) begin
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                s_tvalid <= 1'b0;
            end else if (!quiet && $urandom_range(0, 9) == 0) begin
                gap_left <= $urandom_range(0, 7);   // start a burst of idle cycles
                s_tvalid <= 1'b0;
            end else if (pending_reqs.size() > 0) begin
                rq = pending_reqs.pop_front();
                s_tuser  <= rq.kind;
                s_tdata  <= {6'd0, rq.frame};
                s_tvalid <= 1'b1;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // ---- receiver: random back-pressure plus one long hold-off ----
    int  hold_left = 0;
    int  rx_gap = 0;
    bit  long_hold_done = 0;
    always @(negedge aclk) begin
        if (!long_hold_done && beats_in >= 600) begin
            long_hold_done <= 1;
            hold_left <= 400;
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_tready <= 1'b0;
        end else if (rx_gap > 0) begin
            rx_gap <= rx_gap - 1;
            m_tready <= 1'b0;
        end else if (!quiet && $urandom_range(0, 9) == 0) begin
            rx_gap <= $urandom_range(0, 7);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // ---- monitor: sampled at the rising edge ----
    always @(posedge aclk) begin
        grant_t want, got;
        bit     moved;
        moved = 0;
        in_done <= aresetn && s_tvalid && s_tready;
        if (aresetn && s_tvalid && s_tready) begin
            expected_grants.push_back(
                serve_request('{kind: kind_t'(s_tuser), frame: s_tdata[9:0]}));
            beats_in <= beats_in + 1;
            moved = 1;
        end
        if (aresetn && m_tvalid && m_tready) begin
            moved = 1;
            got = '{granted: m_tdata[9:0], status: status_t'(m_tuser[2:0]),
                    writeback: m_tuser[3]};
            if (expected_grants.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result beat: frame %0d status %0d wb %0d",
                             got.granted, got.status, got.writeback);
            end else begin
                want = expected_grants.pop_front();
                if (got !== want) begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch: exp frame %0d st %0d wb %0d, got %0d %0d %0d",
                                 want.granted, want.status, want.writeback,
                                 got.granted, got.status, got.writeback);
                end
            end
        end
        idle_cycles <= moved ? 0 : idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic queue_req(kind_t k, int f);
        pending_reqs.push_back('{kind: k, frame: f[9:0]});
    endtask

    initial begin
        int allocs, pick, top;
        shadow_reset();
        repeat (6) @(posedge aclk);
        @(negedge aclk) aresetn = 1'b1;

        // directed: absent frames, field extremes, hand release, last release
        queue_req(KIND_REF, 5);
        queue_req(KIND_RELEASE, 7);
        queue_req(KIND_DIRTY, 1023);
        queue_req(KIND_DIRTY, 0);
        queue_req(KIND_ALLOC, 1023);
        queue_req(KIND_ALLOC, 0);
        queue_req(KIND_ALLOC, 0);
        queue_req(KIND_REF, 1);
        queue_req(KIND_REF, 0);
        queue_req(KIND_RELEASE, 2);   // hand moves back
        queue_req(KIND_RELEASE, 1);
        queue_req(KIND_RELEASE, 0);   // ring empties
        queue_req(KIND_ALLOC, 0);
        queue_req(KIND_RELEASE, 1023);
        queue_req(KIND_REF, 1023);
        queue_req(KIND_ALLOC, 0);
        queue_req(KIND_REF, 4);
        queue_req(KIND_DIRTY, 4);
        allocs = 21;

        // fill: mostly allocates until the free queue runs dry
        for (int i = 0; i < 1150; i++) begin
            pick = $urandom_range(0, 99);
            top = (allocs < FRAMES) ? allocs : FRAMES - 1;
            if (pick < 92) begin
                queue_req(KIND_ALLOC, $urandom_range(0, 1023));
                allocs++;
            end else if (pick < 96) begin
                queue_req(KIND_REF, $urandom_range(0, top));
            end else if (pick < 98) begin
                queue_req(KIND_DIRTY, $urandom_range(0, top));
            end else begin
                queue_req(KIND_RELEASE, $urandom_range(0, top));
            end
        end

        // sender pause until every result is back
        wait (pending_reqs.size() == 0 && !s_tvalid && expected_grants.size() == 0);

        // replacement phase on a full ring
        for (int i = 0; i < 700; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 40)      queue_req(KIND_ALLOC, $urandom_range(0, 1023));
            else if (pick < 75) queue_req(KIND_REF, $urandom_range(0, 1023));
            else if (pick < 87) queue_req(KIND_DIRTY, $urandom_range(0, 1023));
            else                queue_req(KIND_RELEASE, $urandom_range(0, 1023));
        end

        wait (pending_reqs.size() < 150);
        quiet = 1;
        wait (pending_reqs.size() == 0 && !s_tvalid && expected_grants.size() == 0);
        repeat (50) @(posedge aclk);
        if (errors == 0 && expected_grants.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
